@@ hdl/text_display_word_decoder_assert.svh @@
// assertion macros for the text display word decoder
`ifndef TEXT_DISPLAY_WORD_DECODER_ASSERT_SVH
`define TEXT_DISPLAY_WORD_DECODER_ASSERT_SVH

`ifndef SYNTH

`define TDWD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("tdwd assertion failed");

`define TDWD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("tdwd assertion failed");

`else

`define TDWD_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons)

`define TDWD_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons)

`endif

`endif

@@ hdl/tdwd_pkg.sv @@
// package with codes and character helpers for the text display word decoder
package tdwd_pkg;

  localparam logic [1:0] REQ_FRAME = 2'd0;
  localparam logic [1:0] REQ_WORD  = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  localparam logic [7:0] WT_CHAR = 8'h03;
  localparam logic [7:0] WT_CMD  = 8'h02;

  localparam logic [7:0] CMD_CLEAR = 8'h06;
  localparam logic [7:0] CMD_HOME  = 8'h02;
  localparam logic [7:0] CMD_LINE2 = 8'hC0;

  localparam logic [7:0] SYM_BLOCK  = 8'd11;
  localparam logic [7:0] SYM_ARROW  = 8'd16;
  localparam logic [7:0] SYM_CIRCLE = 8'd22;
  localparam logic [7:0] SYM_NOTE   = 8'd145;
  localparam logic [7:0] SYM_BELL   = 8'd152;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;

  function automatic logic [7:0] filter_char(input logic [7:0] c);
    logic sym;
    logic printable;
    sym = (c == SYM_BLOCK) || (c == SYM_ARROW) || (c == SYM_CIRCLE) ||
          (c == SYM_NOTE) || (c == SYM_BELL);
    printable = (c >= CHAR_SPACE) && (c <= CHAR_TILDE);
    return (sym || printable) ? c : CHAR_SPACE;
  endfunction

  function automatic logic [7:0] map_symbol(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      SYM_BLOCK:  r = 8'h23;
      SYM_ARROW:  r = 8'h3E;
      SYM_CIRCLE: r = 8'h40;
      SYM_NOTE:   r = CHAR_SPACE;
      SYM_BELL:   r = 8'h6F;
      default:    r = c;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/tdwd_in_if.sv @@
// input word channel of the text display word decoder
interface tdwd_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [7:0] word_type;
  logic [7:0] word_value;
  logic [6:0] read_addr;

  modport source (output valid, req_type, word_type, word_value, read_addr, input ready);
  modport sink (input valid, req_type, word_type, word_value, read_addr, output ready);
endinterface

@@ hdl/tdwd_out_if.sv @@
// result word channel of the text display word decoder
interface tdwd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_char;
  logic [6:0] cursor;

  modport source (output valid, read_char, cursor, input ready);
  modport sink (input valid, read_char, cursor, output ready);
endinterface

@@ hdl/text_display_word_decoder.sv @@
// text display word decoder: two-line character store with write cursor
// input stage, then result stage; both hold while a result waits on dout.ready
// one word per cycle unless stalled; store write, cursor update in one stage
// character store is a memory with one valid bit per entry; clear resets them all
// reset: cursor 0, all entries read as space, both pipeline stages empty
`include "text_display_word_decoder_assert.svh"

module text_display_word_decoder #(
  parameter int LINE_LENGTH = 40
) (
  input  logic             clk,
  input  logic             rst,
  tdwd_in_if.sink          din,
  tdwd_out_if.source       dout
);

  localparam int STORE_SIZE = 2 * LINE_LENGTH;
  localparam int POS_W      = $clog2(STORE_SIZE + 1);
  localparam int ADDR_W     = $clog2(STORE_SIZE);

  logic [7:0]            mem [STORE_SIZE];
  logic [STORE_SIZE-1:0] filled;
  logic [POS_W-1:0]      write_pos;
  logic [POS_W-1:0]      write_pos_next;

  logic                  s1_valid;
  logic [1:0]            s1_req;
  logic [7:0]            s1_wtype;
  logic [7:0]            s1_wval;
  logic [6:0]            s1_raddr;

  logic                  out_valid;
  logic                  out_is_read;
  logic                  out_in_range;
  logic                  out_filled;
  logic [7:0]            rdata;
  logic [6:0]            out_cursor;

  logic                  adv;
  logic                  proc;
  logic                  mem_we;
  logic                  clear_all;
  logic                  rd_en;
  logic                  rd_in_range;
  logic [ADDR_W-1:0]     wr_idx;
  logic [ADDR_W-1:0]     rd_idx;

  assign adv       = !out_valid || dout.ready;
  assign proc      = adv && s1_valid;
  assign din.ready = adv;

  assign wr_idx      = write_pos[ADDR_W-1:0];
  assign rd_idx      = s1_raddr[ADDR_W-1:0];
  assign rd_in_range = {1'b0, s1_raddr} < 8'(STORE_SIZE);

  always_comb begin
    write_pos_next = write_pos;
    mem_we         = 1'b0;
    clear_all      = 1'b0;
    rd_en          = 1'b0;
    if (proc) begin
      case (s1_req)
        tdwd_pkg::REQ_FRAME: begin
          clear_all      = 1'b1;
          write_pos_next = '0;
        end
        tdwd_pkg::REQ_WORD: begin
          if (s1_wtype == tdwd_pkg::WT_CHAR) begin
            if (write_pos < POS_W'(STORE_SIZE)) begin
              mem_we         = 1'b1;
              write_pos_next = POS_W'(write_pos + 1'b1);
            end
          end else if (s1_wtype == tdwd_pkg::WT_CMD) begin
            if (s1_wval == tdwd_pkg::CMD_CLEAR) begin
              clear_all = 1'b1;
            end else if (s1_wval == tdwd_pkg::CMD_HOME) begin
              write_pos_next = '0;
            end else if (s1_wval == tdwd_pkg::CMD_LINE2) begin
              write_pos_next = POS_W'(LINE_LENGTH);
            end
          end
        end
        tdwd_pkg::REQ_READ: begin
          rd_en = rd_in_range;
        end
        default: begin
        end
      endcase
    end
  end

  // character memory
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_idx] <= tdwd_pkg::filter_char(s1_wval);
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      write_pos <= '0;
    end else begin
      write_pos <= write_pos_next;
      if (clear_all) begin
        filled <= '0;
      end else if (mem_we) begin
        filled[wr_idx] <= 1'b1;
      end
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_req   <= din.req_type;
      s1_wtype <= din.word_type;
      s1_wval  <= din.word_value;
      s1_raddr <= din.read_addr;
    end
  end

  // result stage
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      out_is_read  <= (s1_req == tdwd_pkg::REQ_READ);
      out_in_range <= rd_in_range;
      out_filled   <= filled[rd_idx];
      out_cursor   <= 7'(write_pos_next);
    end
  end

  assign dout.valid     = out_valid;
  assign dout.cursor    = out_cursor;
  assign dout.read_char = !out_is_read ? 8'h00 :
                          (!out_in_range || !out_filled) ? tdwd_pkg::CHAR_SPACE :
                          tdwd_pkg::map_symbol(rdata);

  `TDWD_ASSERT_IMP(a_pos_bound, clk, rst, 1'b1, write_pos <= POS_W'(STORE_SIZE))
  `TDWD_ASSERT_NXT(a_frame_clear, clk, rst, proc && s1_req == tdwd_pkg::REQ_FRAME,
                   write_pos == '0 && filled == '0)
  `TDWD_ASSERT_NXT(a_char_adv, clk, rst, mem_we, write_pos == POS_W'($past(write_pos) + 1'b1))
  `TDWD_ASSERT_IMP(a_cursor_track, clk, rst, out_valid, out_cursor == 7'(write_pos))

endmodule
